### sv/stwit_pkg.sv
// Shared types and constants for the session table with idle timeout.
// Holds request and status codes, the scan token and the write command.
// No dependencies.
package stwit_pkg;

    // Request codes
    localparam logic [1:0] REQ_CREATE  = 2'd0;
    localparam logic [1:0] REQ_DELETE  = 2'd1;
    localparam logic [1:0] REQ_CONFIRM = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    // Field widths
    localparam int KEY_W  = 64;
    localparam int TIME_W = 64;
    localparam int TMO_W  = 32;
    localparam int SLOT_W = 6;

    // Register reset value: 30 minutes in ms
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(30 * 60 * 1000);

    // Entry update kinds
    typedef enum logic [1:0] {
        WR_CREATE,
        WR_CLEAR,
        WR_REFRESH
    } wr_op_t;

    // Write command broadcast to every cell
    typedef struct packed {
        logic   en;
        wr_op_t op;
    } wr_cmd_t;

    // Scan token flags handed from cell to cell
    typedef struct packed {
        logic active;
        logic prim_hit;
        logic sec_hit;
    } scan_tok_t;

endpackage

### sv/stwit_cell.sv
// One table entry of the session table, one link of the scan chain.
// Checks its entry against the passing scan token and applies broadcast writes.
// Depends on stwit_pkg.
module stwit_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    req_type,
    input  logic [stwit_pkg::KEY_W-1:0]   user_key,
    input  logic [stwit_pkg::KEY_W-1:0]   session_key,
    input  logic [stwit_pkg::TIME_W-1:0]  now_ms,
    input  logic                          match_session_only,
    input  logic [stwit_pkg::TMO_W-1:0]   idle_timeout_ms,
    input  stwit_pkg::scan_tok_t          tok_in,
    input  logic [IDX_W-1:0]              prim_idx_in,
    input  logic [IDX_W-1:0]              sec_idx_in,
    output stwit_pkg::scan_tok_t          tok_out,
    output logic [IDX_W-1:0]              prim_idx_out,
    output logic [IDX_W-1:0]              sec_idx_out,
    input  stwit_pkg::wr_cmd_t            wr_cmd,
    input  logic [IDX_W-1:0]              wr_idx
);
    import stwit_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic                valid_reg,   valid_next;
    logic [KEY_W-1:0]    user_reg,    user_next;
    logic [KEY_W-1:0]    session_reg, session_next;
    logic [TIME_W-1:0]   time_reg,    time_next;

    scan_tok_t           tok_reg,      tok_next;
    logic [IDX_W-1:0]    prim_idx_reg, prim_idx_next;
    logic [IDX_W-1:0]    sec_idx_reg,  sec_idx_next;

    logic                user_eq;
    logic                sess_eq;
    logic [TIME_W-1:0]   age;
    logic                expired;
    logic                prim_cond;

    // Compare stored entry against the request
    assign user_eq = (user_reg == user_key);
    assign sess_eq = (session_reg == session_key);
    assign age     = now_ms - time_reg;
    assign expired = (age >= TIME_W'(idle_timeout_ms));

    // Select the primary match rule for this request
    always_comb
    begin
        case (req_type)
            REQ_CREATE:  prim_cond = valid_reg && user_eq;
            REQ_DELETE:  prim_cond = valid_reg && user_eq && sess_eq;
            REQ_CONFIRM: prim_cond = valid_reg && (match_session_only || user_eq)
                                     && sess_eq && !expired;
            default:     prim_cond = 1'b0;
        endcase
    end

    // Advance the token, recording the first hit of each kind
    always_comb
    begin
        tok_next      = tok_in;
        prim_idx_next = prim_idx_in;
        sec_idx_next  = sec_idx_in;
        if (tok_in.active)
        begin
            if (!tok_in.prim_hit && prim_cond)
            begin
                tok_next.prim_hit = 1'b1;
                prim_idx_next     = MY_IDX;
            end
            if (!tok_in.sec_hit && expired)
            begin
                tok_next.sec_hit = 1'b1;
                sec_idx_next     = MY_IDX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prim_idx_reg <= prim_idx_next;
        sec_idx_reg  <= sec_idx_next;
    end

    assign tok_out      = tok_reg;
    assign prim_idx_out = prim_idx_reg;
    assign sec_idx_out  = sec_idx_reg;

    // Apply a write addressed to this entry
    always_comb
    begin
        valid_next   = valid_reg;
        user_next    = user_reg;
        session_next = session_reg;
        time_next    = time_reg;
        if (wr_cmd.en && (wr_idx == MY_IDX))
        begin
            unique case (wr_cmd.op)
                WR_CREATE:
                begin
                    valid_next   = 1'b1;
                    user_next    = user_key;
                    session_next = session_key;
                    time_next    = now_ms;
                end
                WR_CLEAR:
                begin
                    valid_next   = 1'b0;
                    user_next    = '0;
                    session_next = '0;
                    time_next    = '0;
                end
                WR_REFRESH:
                begin
                    time_next = now_ms;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    // Entry storage; reset value is part of the behavior (time 0)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            user_reg    <= '0;
            session_reg <= '0;
            time_reg    <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            user_reg    <= user_next;
            session_reg <= session_next;
            time_reg    <= time_next;
        end
    end

endmodule

### sv/session_table_with_idle_timeout_core.sv
// Top level of the session table with idle timeout: request capture, scan
// chain of entry cells, commit decision, result strobe and APB register.
// Depends on stwit_pkg and stwit_cell.

// A request is taken when start is high and busy is low. A scan token then
// walks the row of ENTRIES entry cells, one cell per clock, collecting the
// first matching entry and the first expired entry. When it leaves the last
// cell the block commits the update and, in the next cycle, raises done for a
// single cycle with status and slot. On its way from acceptance to done a
// request passes the inject register, the ENTRIES cell registers and the done
// register; busy drops in the cycle done is shown, so a new request can be
// accepted back to back in that cycle. done cannot be held off: the receiver must capture
// status and slot in that cycle. Write idle_timeout_ms only while busy is low.
module session_table_with_idle_timeout_core #(
    parameter int ENTRIES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    req_type,
    input  logic [stwit_pkg::KEY_W-1:0]   user_key,
    input  logic [stwit_pkg::KEY_W-1:0]   session_key,
    input  logic [stwit_pkg::TIME_W-1:0]  now_ms,
    input  logic                          refresh_time,
    input  logic                          match_session_only,
    // result
    output logic                          done,
    output logic [1:0]                    status,
    output logic [stwit_pkg::SLOT_W-1:0]  slot,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import stwit_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Request registers, broadcast to all cells during the scan
    logic [1:0]          req_type_reg;
    logic [KEY_W-1:0]    user_key_reg;
    logic [KEY_W-1:0]    session_key_reg;
    logic [TIME_W-1:0]   now_ms_reg;
    logic                refresh_reg;
    logic                sess_only_reg;

    logic                busy_reg,   busy_next;
    logic                inject_reg, inject_next;
    logic                done_reg,   done_next;
    logic [1:0]          status_reg, status_next;
    logic [SLOT_W-1:0]   slot_reg,   slot_next;
    logic [TMO_W-1:0]    timeout_reg, timeout_next;

    logic                accept;
    logic                commit;
    logic                cfg_wr;
    wr_cmd_t             wr_cmd;
    logic [IDX_W-1:0]    wr_idx;

    scan_tok_t           tok      [ENTRIES+1];
    logic [IDX_W-1:0]    prim_idx [ENTRIES+1];
    logic [IDX_W-1:0]    sec_idx  [ENTRIES+1];

    assign accept = start && !busy_reg;
    assign commit = tok[ENTRIES].active;

    // Capture request fields on transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg    <= req_type;
            user_key_reg    <= user_key;
            session_key_reg <= session_key;
            now_ms_reg      <= now_ms;
            refresh_reg     <= refresh_time;
            sess_only_reg   <= match_session_only;
        end
    end

    // Inject a fresh token at the head of the chain
    assign tok[0].active   = inject_reg;
    assign tok[0].prim_hit = 1'b0;
    assign tok[0].sec_hit  = 1'b0;
    assign prim_idx[0]     = '0;
    assign sec_idx[0]      = '0;

    // Row of entry cells
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        stwit_cell #(
            .INDEX (g),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk                (clk),
            .rst_n              (rst_n),
            .req_type           (req_type_reg),
            .user_key           (user_key_reg),
            .session_key        (session_key_reg),
            .now_ms             (now_ms_reg),
            .match_session_only (sess_only_reg),
            .idle_timeout_ms    (timeout_reg),
            .tok_in             (tok[g]),
            .prim_idx_in        (prim_idx[g]),
            .sec_idx_in         (sec_idx[g]),
            .tok_out            (tok[g+1]),
            .prim_idx_out       (prim_idx[g+1]),
            .sec_idx_out        (sec_idx[g+1]),
            .wr_cmd             (wr_cmd),
            .wr_idx             (wr_idx)
        );
    end

    // Decide the update and the result when the token leaves the chain
    always_comb
    begin
        wr_cmd.en   = 1'b0;
        wr_cmd.op   = WR_CREATE;
        wr_idx      = prim_idx[ENTRIES];
        status_next = ST_NOMATCH;
        slot_next   = '0;
        if (commit)
        begin
            case (req_type_reg)
                REQ_CREATE:
                begin
                    if (tok[ENTRIES].prim_hit)
                    begin
                        wr_cmd.en   = 1'b1;
                        status_next = ST_OK;
                        slot_next   = SLOT_W'(prim_idx[ENTRIES]);
                    end
                    else if (tok[ENTRIES].sec_hit)
                    begin
                        wr_cmd.en   = 1'b1;
                        wr_idx      = sec_idx[ENTRIES];
                        status_next = ST_OK;
                        slot_next   = SLOT_W'(sec_idx[ENTRIES]);
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                REQ_DELETE:
                begin
                    if (tok[ENTRIES].prim_hit)
                    begin
                        wr_cmd.en   = 1'b1;
                        wr_cmd.op   = WR_CLEAR;
                        status_next = ST_OK;
                        slot_next   = SLOT_W'(prim_idx[ENTRIES]);
                    end
                end
                REQ_CONFIRM:
                begin
                    if (tok[ENTRIES].prim_hit)
                    begin
                        wr_cmd.en   = refresh_reg;
                        wr_cmd.op   = WR_REFRESH;
                        status_next = ST_OK;
                        slot_next   = SLOT_W'(prim_idx[ENTRIES]);
                    end
                end
                default:
                begin
                    status_next = ST_NOMATCH;
                end
            endcase
        end
    end

    // Sequence control: busy from transfer to commit
    always_comb
    begin
        busy_next   = busy_reg;
        inject_next = accept;
        done_next   = commit;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (commit)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            inject_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            inject_reg <= inject_next;
            done_reg   <= done_next;
        end
    end

    // Hold the result for its one strobe cycle
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign status = status_reg;
    assign slot   = slot_reg;

    // Configuration register; byte offset bits within the word are ignored
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

    always_comb
    begin
        timeout_next = timeout_reg;
        if (cfg_wr)
        begin
            timeout_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? timeout_reg : 32'd0;
    assign pready = 1'b1;

    // A result strobe is raised only in the cycle after a commit
    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(commit))
        else $error("done without a preceding commit");

    // No token may reach the chain end while idle
    a_no_token_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !commit)
        else $error("scan token active while idle");

    // An accepted request keeps the block busy and launches a token
    a_accept_launch: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg && inject_reg))
        else $error("accepted request did not launch a scan");

    // Failed requests report slot zero
    a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != ST_OK)) |-> (slot_reg == '0))
        else $error("nonzero slot on failed request");

    // A write to the table only happens on commit
    a_write_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        wr_cmd.en |-> commit)
        else $error("table write outside commit");

endmodule
